FILE: hw/rtl/lrc_pkg.sv
// Shared types and codes for the LRU result cache.
package lrc_pkg;

    localparam int COLL_BITS = 8;
    localparam int OCC_BITS  = 9;
    localparam int CAP_BITS  = 9;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_RED,
        ST_UPD
    } lrc_state_t;

    typedef struct packed {
        logic cmp;  // register the match flag of every cell
        logic upd;  // shift cells up to the limit index
    } lrc_ctl_t;

endpackage

FILE: hw/rtl/lrc_cell.sv
// One cache cell: holds one entry, matches it and takes its neighbor's entry on a shift.
module lrc_cell
    import lrc_pkg::*;
#(
    parameter int INDEX      = 0,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 32,
    parameter int IW         = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lrc_ctl_t              ctl,
    input  logic [IW-1:0]         shift_limit,
    input  logic [COLL_BITS-1:0]  req_coll,
    input  logic [KEY_BITS-1:0]   req_key,
    input  logic                  nb_valid,
    input  logic [COLL_BITS-1:0]  nb_coll,
    input  logic [KEY_BITS-1:0]   nb_key,
    input  logic [VALUE_BITS-1:0] nb_value,
    output logic                  valid,
    output logic [COLL_BITS-1:0]  coll,
    output logic [KEY_BITS-1:0]   key,
    output logic [VALUE_BITS-1:0] value,
    output logic                  match
);

    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

    logic                  valid_reg;
    logic                  match_reg;
    logic [COLL_BITS-1:0]  coll_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic                  shift_en;

    assign shift_en = ctl.upd && (shift_limit >= MY_IDX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            if (shift_en)
            begin
                valid_reg <= nb_valid;
            end
            if (ctl.cmp)
            begin
                match_reg <= valid_reg && (coll_reg == req_coll) && (key_reg == req_key);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            coll_reg  <= nb_coll;
            key_reg   <= nb_key;
            value_reg <= nb_value;
        end
    end

    assign valid = valid_reg;
    assign coll  = coll_reg;
    assign key   = key_reg;
    assign value = value_reg;
    assign match = match_reg;

endmodule

FILE: hw/rtl/lrc_reduce.sv
// Folds the one-hot match flags into hit, matched position and matched value.
module lrc_reduce
    import lrc_pkg::*;
#(
    parameter int ENTRIES    = 256,
    parameter int VALUE_BITS = 32,
    parameter int IW         = 8
)
(
    input  logic                  clk,
    input  logic                  en,
    input  logic [ENTRIES-1:0]    match,
    input  logic [VALUE_BITS-1:0] value [ENTRIES],
    output logic                  hit,
    output logic [IW-1:0]         idx,
    output logic [VALUE_BITS-1:0] hit_value
);

    logic                  hit_reg;
    logic [IW-1:0]         idx_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [IW-1:0]         idx_c;
    logic [VALUE_BITS-1:0] value_c;

    // at most one cell matches, so an OR tree acts as the select
    always_comb
    begin
        idx_c   = '0;
        value_c = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (match[i])
            begin
                idx_c   = idx_c | IW'(i);
                value_c = value_c | value[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg   <= |match;
            idx_reg   <= idx_c;
            value_reg <= value_c;
        end
    end

    assign hit       = hit_reg;
    assign idx       = idx_reg;
    assign hit_value = value_reg;

endmodule

FILE: hw/rtl/lru_result_cache.sv
// Top level of the fully associative LRU result cache.
// An item is accepted in the idle state and then passes the compare, reduce and
// update states in turn. Its result is loaded into the output register in the
// update state; a new item is accepted only once the cache is idle again.
// In the compare cycle the cells match the request in parallel. In the reduce
// cycle a registered OR tree folds the match flags into hit, position and value.
// In the update cycle the chain of cells shifts once. Cells are kept
// in recency order (cell 0 most recent); a hit or insert moves every cell up
// to the matched, freed or evicted position one place down and loads the
// entry into cell 0. A get miss leaves the cells unchanged. The result sits in
// an output register; the next item is accepted while it waits, and the
// update step stalls only if the previous result has not yet been taken.
module lru_result_cache
    import lrc_pkg::*;
#(
    parameter int ENTRIES    = 256,
    parameter int KEY_BITS   = 64,
    parameter int VALUE_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CAP_BITS-1:0]  cfg_wr_data,  // capacity
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // collection_id, query_key, value_in (from bit 0), zero fill to bytes
    input  logic [((COLL_BITS+KEY_BITS+VALUE_BITS+7)/8)*8-1:0] s_tdata,
    input  logic                 s_tuser,      // opcode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // value_out, occupancy (from bit 0), zero fill to bytes
    output logic [((VALUE_BITS+OCC_BITS+7)/8)*8-1:0] m_tdata,
    output logic                 m_tuser       // hit
);

    localparam int IW    = $clog2(ENTRIES);
    localparam int CW    = $clog2(ENTRIES + 1);
    localparam int CMPW  = (CW > CAP_BITS) ? CW : CAP_BITS;
    localparam int OUT_W = ((VALUE_BITS + OCC_BITS + 7) / 8) * 8;
    localparam logic [CMPW-1:0] N_EXT = CMPW'(ENTRIES);

    lrc_state_t state_reg, state_next;
    lrc_ctl_t   ctl;

    logic [CAP_BITS-1:0]   cap_reg;
    logic [CW-1:0]         count_reg, count_next;
    logic                  req_put_reg;
    logic [COLL_BITS-1:0]  req_coll_reg;
    logic [KEY_BITS-1:0]   req_key_reg;
    logic [VALUE_BITS-1:0] req_value_reg;

    logic                  out_valid_reg;
    logic                  out_hit_reg;
    logic [VALUE_BITS-1:0] out_value_reg;
    logic [OCC_BITS-1:0]   out_occ_reg;

    logic                  accept;
    logic                  load_out;
    logic                  out_free;

    logic                  red_en;
    logic                  red_hit;
    logic [IW-1:0]         red_idx;
    logic [VALUE_BITS-1:0] red_value;

    logic [CMPW-1:0]       cap_ext, cnt_ext, eff_cap;
    logic                  evict;
    logic [IW-1:0]         shift_limit;
    logic [VALUE_BITS-1:0] head_value;
    logic [VALUE_BITS-1:0] vout;

    logic                  cell_valid [ENTRIES];
    logic [COLL_BITS-1:0]  cell_coll  [ENTRIES];
    logic [KEY_BITS-1:0]   cell_key   [ENTRIES];
    logic [VALUE_BITS-1:0] cell_value [ENTRIES];
    logic [ENTRIES-1:0]    cell_match;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        s_tready   = 1'b0;
        red_en     = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                ctl.cmp    = 1'b1;
                state_next = ST_RED;
            end
            ST_RED:
            begin
                red_en     = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (out_free)
                begin
                    ctl.upd    = red_hit || (req_put_reg == OP_PUT);
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // capacity zero acts as one, above the cell count acts as the cell count
    assign cap_ext = CMPW'(cap_reg);
    assign cnt_ext = CMPW'(count_reg);
    assign eff_cap = (cap_ext == '0) ? CMPW'(1) : ((cap_ext > N_EXT) ? N_EXT : cap_ext);
    assign evict   = cnt_ext >= eff_cap;

    always_comb
    begin
        if (red_hit)
        begin
            shift_limit = red_idx;
        end
        else if (evict)
        begin
            shift_limit = IW'(count_reg - CW'(1));
        end
        else
        begin
            shift_limit = IW'(count_reg);
        end
    end

    assign head_value = (red_hit && (req_put_reg == OP_GET)) ? red_value : req_value_reg;
    assign vout       = (red_hit && (req_put_reg == OP_GET)) ? red_value : '0;

    always_comb
    begin
        count_next = count_reg;
        if ((req_put_reg == OP_PUT) && !red_hit && !evict)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_BITS'(256);
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
            if (load_out)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_put_reg   <= s_tuser;
            req_coll_reg  <= s_tdata[COLL_BITS-1:0];
            req_key_reg   <= s_tdata[COLL_BITS +: KEY_BITS];
            req_value_reg <= s_tdata[COLL_BITS+KEY_BITS +: VALUE_BITS];
        end
        if (load_out)
        begin
            out_hit_reg   <= red_hit;
            out_value_reg <= vout;
            out_occ_reg   <= OCC_BITS'(count_next);
        end
    end

    generate
        for (genvar i = 0; i < ENTRIES; i++)
        begin : g_cell
            logic                  nb_valid;
            logic [COLL_BITS-1:0]  nb_coll;
            logic [KEY_BITS-1:0]   nb_key;
            logic [VALUE_BITS-1:0] nb_value;

            if (i == 0)
            begin : g_head
                assign nb_valid = 1'b1;
                assign nb_coll  = req_coll_reg;
                assign nb_key   = req_key_reg;
                assign nb_value = head_value;
            end
            else
            begin : g_link
                assign nb_valid = cell_valid[i-1];
                assign nb_coll  = cell_coll[i-1];
                assign nb_key   = cell_key[i-1];
                assign nb_value = cell_value[i-1];
            end

            lrc_cell #(
                .INDEX      (i),
                .KEY_BITS   (KEY_BITS),
                .VALUE_BITS (VALUE_BITS),
                .IW         (IW)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .shift_limit (shift_limit),
                .req_coll    (req_coll_reg),
                .req_key     (req_key_reg),
                .nb_valid    (nb_valid),
                .nb_coll     (nb_coll),
                .nb_key      (nb_key),
                .nb_value    (nb_value),
                .valid       (cell_valid[i]),
                .coll        (cell_coll[i]),
                .key         (cell_key[i]),
                .value       (cell_value[i]),
                .match       (cell_match[i])
            );
        end
    endgenerate

    lrc_reduce #(
        .ENTRIES    (ENTRIES),
        .VALUE_BITS (VALUE_BITS),
        .IW         (IW)
    ) u_reduce (
        .clk       (clk),
        .en        (red_en),
        .match     (cell_match),
        .value     (cell_value),
        .hit       (red_hit),
        .idx       (red_idx),
        .hit_value (red_value)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_hit_reg;
    assign m_tdata  = OUT_W'({out_occ_reg, out_value_reg});

endmodule
